/* rtl/lsbs_pkg.sv */
package lsbs_pkg;

    // event codes
    localparam logic [2:0] FUNC_TICK      = 3'd0;
    localparam logic [2:0] FUNC_SET_MODE  = 3'd1;
    localparam logic [2:0] FUNC_PULSE     = 3'd2;
    localparam logic [2:0] FUNC_RAISE     = 3'd3;
    localparam logic [2:0] FUNC_CLEAR     = 3'd4;
    localparam logic [2:0] FUNC_CLEAR_ALL = 3'd5;

    // status modes
    localparam logic [2:0] MODE_BOOTING    = 3'd0;
    localparam logic [2:0] MODE_WAITING    = 3'd1;
    localparam logic [2:0] MODE_CONNECTING = 3'd2;
    localparam logic [2:0] MODE_CONNECTED  = 3'd3;
    localparam logic [2:0] MODE_READY      = 3'd4;
    localparam logic [2:0] MODE_ERROR      = 3'd5;

    // pulse kinds
    localparam logic [1:0] PULSE_NONE    = 2'd0;
    localparam logic [1:0] PULSE_SUCCESS = 2'd1;
    localparam logic [1:0] PULSE_FAILURE = 2'd2;

    localparam int unsigned DEFAULT_FAULT_SLOTS = 8;
    localparam logic [7:0]  BRIGHTNESS_RESET    = 8'd16;

    // blink code timing, ms
    localparam logic [31:0] FLASH_ON_MS  = 32'd180;
    localparam logic [31:0] FLASH_OFF_MS = 32'd140;
    localparam logic [31:0] CODE_GAP_MS  = 32'd500;

    // parity of now / period for the blinking modes (1 = odd half, dark)
    typedef struct packed {
        logic odd_400;
        logic odd_600;
        logic odd_500;
    } phase_t;

endpackage

/* rtl/lsbs_phase.sv */
module lsbs_phase (
    input  logic [31:0]          now_ms,
    output lsbs_pkg::phase_t     phase
);
    import lsbs_pkg::*;

    // floor(x / d) by reciprocal: q = (x * ceil(2^k / d)) >> k, exact for the
    // given x range. 400 = 16*25, 600 = 8*75, 500 = 4*125.
    localparam logic [28:0] RECIP_25  = 29'd343597384;   // k = 33, x < 2^28
    localparam logic [29:0] RECIP_75  = 30'd916259690;   // k = 36, x < 2^29
    localparam logic [30:0] RECIP_125 = 31'd1099511628;  // k = 37, x < 2^30

    logic [56:0] prod_400;
    logic [58:0] prod_600;
    logic [60:0] prod_500;

    assign prod_400 = 57'(now_ms[31:4]) * 57'(RECIP_25);
    assign prod_600 = 59'(now_ms[31:3]) * 59'(RECIP_75);
    assign prod_500 = 61'(now_ms[31:2]) * 61'(RECIP_125);

    assign phase.odd_400 = prod_400[33];
    assign phase.odd_600 = prod_600[36];
    assign phase.odd_500 = prod_500[37];

endmodule

/* rtl/led_status_blink_sequencer.sv */
// RGB status LED sequencer.
// Input channel (s_valid/s_ready): one request per event. s_func selects tick,
// set mode, trigger pulse, raise fault, clear fault or clear all; s_now_ms is
// the current millisecond time. Only a tick can make a result.
// Result channel (m_valid/m_ready): one request carrying the new red/green/blue
// intensity, sent only when the color differs from the last one sent.
// Config: cfg_wr_en/cfg_wr_data write brightness; write only idle.
// An accepted request waits in the input register, is processed once the output
// register is free; its result is registered onto m_*. One request per cycle while
// m_ready keeps up: the single input register -> processing -> output register pass.
// The mode blink phases (now/400, now/600, now/500) come from reciprocal
// multipliers ahead of the input register.
// Reset (aresetn low, synchronous): mode booting, no pulse, no faults, blink
// code at step 0 and due now, last color black, brightness 16, both channels
// empty. When the receiver stalls, the result holds in the output register and
// one more request is still taken into the input register; after that
// s_ready drops until m_ready frees the output.
module led_status_blink_sequencer #(
    parameter int unsigned FAULT_SLOTS = lsbs_pkg::DEFAULT_FAULT_SLOTS
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [31:0] s_now_ms,
    input  logic [2:0]  s_mode,
    input  logic [1:0]  s_pulse_kind,
    input  logic [31:0] s_duration_ms,
    input  logic [2:0]  s_fault_code,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,

    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);
    import lsbs_pkg::*;

    localparam int unsigned FIDX_W   = $clog2(FAULT_SLOTS);
    // longest code: 2 * (FAULT_SLOTS - 1) + 3 steps, step counter runs up to it
    localparam logic [6:0]  STEP_MAX = 7'(2 * FAULT_SLOTS + 1);

    // ---------------- input register ----------------
    phase_t      s_phase;

    logic        in_valid_reg;
    logic [2:0]  in_func_reg;
    logic [31:0] in_now_reg;
    logic [2:0]  in_mode_reg;
    logic [1:0]  in_kind_reg;
    logic [2:0]  in_code_reg;
    logic [31:0] in_pend_reg;   // now + duration, precomputed
    phase_t      in_phase_reg;

    lsbs_phase u_phase (
        .now_ms (s_now_ms),
        .phase  (s_phase)
    );

    // ---------------- state ----------------
    logic [7:0]             brightness_reg;
    logic [2:0]             mode_reg, mode_next;
    logic [1:0]             pulse_reg, pulse_next;
    logic [31:0]            pulse_end_reg, pulse_end_next;
    logic [FAULT_SLOTS-1:0] fault_flags_reg, fault_flags_next;
    logic [6:0]             blink_step_reg, blink_step_next;
    logic [31:0]            next_step_reg, next_step_next;
    logic [23:0]            last_color_reg;

    logic        m_valid_reg;
    logic [7:0]  m_red_reg, m_green_reg, m_blue_reg;

    // ---------------- processing ----------------
    logic                   proc_fire;
    logic                   emit_req;
    logic                   out_load;
    logic [23:0]            color;
    logic [23:0]            mode_color;
    logic [23:0]            pulse_color;
    logic [7:0]             b1, b2, b3;
    logic [FAULT_SLOTS-1:0] code_mask;
    logic [FAULT_SLOTS-1:0] low_oh;
    logic [FAULT_SLOTS-1:0] raise_flags;
    logic [FAULT_SLOTS-1:0] raise_low_oh;
    logic [FIDX_W-1:0]      fault_num;
    logic [6:0]             pairs2;
    logic [6:0]             steps;
    logic [6:0]             step;
    logic                   step_due;
    logic [31:0]            pulse_diff;
    logic                   pulse_live;

    // output slot free -> the held request can be processed
    assign proc_fire = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;

    always_comb begin
        b1 = brightness_reg;
        b2 = {brightness_reg[6:0], 1'b0};
        b3 = b1 + b2;

        // one-hot of the addressed fault; code 0 and codes past the table give none
        for (int i = 0; i < FAULT_SLOTS; i++) begin
            code_mask[i] = (i != 0) && (32'(in_code_reg) == 32'(i));
        end

        // isolate lowest set flag
        low_oh       = fault_flags_reg & (~fault_flags_reg + FAULT_SLOTS'(1));
        raise_flags  = fault_flags_reg | code_mask;
        raise_low_oh = raise_flags & (~raise_flags + FAULT_SLOTS'(1));

        fault_num = '0;
        for (int i = 0; i < FAULT_SLOTS; i++) begin
            if (low_oh[i]) begin
                fault_num = fault_num | FIDX_W'(i);
            end
        end

        // code = red flash, fault_num orange flashes, each with an off step
        pairs2   = (7'(fault_num) + 7'd1) << 1;
        steps    = pairs2 + 7'd1;
        step     = (blink_step_reg >= steps) ? 7'd0 : blink_step_reg;
        step_due = (next_step_reg == 32'd0) || (in_now_reg >= next_step_reg);

        unique case (mode_reg)
            MODE_BOOTING:    mode_color = in_phase_reg.odd_400 ? 24'd0 : {b1, 8'd0, b1};
            MODE_WAITING:    mode_color = in_phase_reg.odd_600 ? 24'd0 : {b1, b1, 8'd0};
            MODE_CONNECTING: mode_color = in_phase_reg.odd_600 ? 24'd0 : {8'd0, 8'd0, b1};
            MODE_CONNECTED:  mode_color = {8'd0, b1, b1};
            MODE_READY:      mode_color = {8'd0, b2, 8'd0};
            MODE_ERROR:      mode_color = in_phase_reg.odd_500 ? 24'd0 : {b2, b1, 8'd0};
            default:         mode_color = 24'd0;
        endcase

        unique case (pulse_reg)
            PULSE_SUCCESS: pulse_color = {8'd0, b3, 8'd0};
            PULSE_FAILURE: pulse_color = {b3, 8'd0, 8'd0};
            default:       pulse_color = 24'd0;
        endcase

        // pulse runs while end - now is positive as a signed value
        pulse_diff = pulse_end_reg - in_now_reg;
        pulse_live = (pulse_diff != 32'd0) && !pulse_diff[31];

        mode_next        = mode_reg;
        pulse_next       = pulse_reg;
        pulse_end_next   = pulse_end_reg;
        fault_flags_next = fault_flags_reg;
        blink_step_next  = blink_step_reg;
        next_step_next   = next_step_reg;
        emit_req         = 1'b0;
        color            = 24'd0;

        if (proc_fire) begin
            unique case (in_func_reg)
                FUNC_TICK: begin
                    if (|fault_flags_reg) begin
                        if (step_due) begin
                            emit_req = 1'b1;
                            if (!step[0] && (step < pairs2)) begin
                                color          = (step == 7'd0) ? {b3, 8'd0, 8'd0}
                                                                : {b3, b2, 8'd0};
                                next_step_next = in_now_reg + FLASH_ON_MS;
                            end else begin
                                color          = 24'd0;
                                next_step_next = in_now_reg +
                                    ((step == steps - 7'd1) ? CODE_GAP_MS : FLASH_OFF_MS);
                            end
                            blink_step_next = step + 7'd1;
                        end
                    end else begin
                        emit_req = 1'b1;
                        color    = mode_color;
                        if (pulse_reg != PULSE_NONE) begin
                            if (pulse_live) begin
                                color = pulse_color;
                            end else begin
                                pulse_next = PULSE_NONE;
                            end
                        end
                    end
                end
                FUNC_SET_MODE: begin
                    mode_next = in_mode_reg;
                end
                FUNC_PULSE: begin
                    pulse_next     = in_kind_reg;
                    pulse_end_next = in_pend_reg;
                end
                FUNC_RAISE: begin
                    if (|code_mask) begin
                        fault_flags_next = raise_flags;
                        if (!(|fault_flags_reg) || (raise_low_oh == code_mask)) begin
                            blink_step_next = 7'd0;
                            next_step_next  = 32'd0;
                        end
                    end
                end
                FUNC_CLEAR: begin
                    if (|code_mask) begin
                        fault_flags_next = fault_flags_reg & ~code_mask;
                        if (low_oh == code_mask) begin
                            blink_step_next = 7'd0;
                            next_step_next  = 32'd0;
                        end
                    end
                end
                FUNC_CLEAR_ALL: begin
                    fault_flags_next = '0;
                    blink_step_next  = 7'd0;
                    next_step_next   = 32'd0;
                end
                default: begin
                end
            endcase
        end

        // only a change of color goes out
        out_load = emit_req && (color != last_color_reg);
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg  <= s_func;
            in_now_reg   <= s_now_ms;
            in_mode_reg  <= s_mode;
            in_kind_reg  <= s_pulse_kind;
            in_code_reg  <= s_fault_code;
            in_pend_reg  <= s_now_ms + s_duration_ms;
            in_phase_reg <= s_phase;
        end
        if (out_load) begin
            m_red_reg   <= color[23:16];
            m_green_reg <= color[15:8];
            m_blue_reg  <= color[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            brightness_reg  <= BRIGHTNESS_RESET;
            mode_reg        <= MODE_BOOTING;
            pulse_reg       <= PULSE_NONE;
            pulse_end_reg   <= 32'd0;
            fault_flags_reg <= '0;
            blink_step_reg  <= 7'd0;
            next_step_reg   <= 32'd0;
            last_color_reg  <= 24'd0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (proc_fire) begin
                in_valid_reg <= 1'b0;
            end

            if (out_load) begin
                m_valid_reg    <= 1'b1;
                last_color_reg <= color;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                brightness_reg <= cfg_wr_data;
            end

            mode_reg        <= mode_next;
            pulse_reg       <= pulse_next;
            pulse_end_reg   <= pulse_end_next;
            fault_flags_reg <= fault_flags_next;
            blink_step_reg  <= blink_step_next;
            next_step_reg   <= next_step_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_red   = m_red_reg;
    assign m_green = m_green_reg;
    assign m_blue  = m_blue_reg;

    // ---------------- checks ----------------
    // fault 0 is never stored
    a_no_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !fault_flags_reg[0])
        else $error("fault slot 0 set");

    // only ticks produce results
    a_emit_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (in_func_reg == FUNC_TICK))
        else $error("result from a non-tick event");

    // a result always carries a new color
    a_color_changes: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (last_color_reg != $past(last_color_reg)))
        else $error("repeated color emitted");

    // processing never overwrites a pending result
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !out_load)
        else $error("pending result overwritten");

    // step counter stays within the longest code
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        blink_step_reg <= STEP_MAX)
        else $error("blink step out of range");

endmodule
